[sv/bcpd_pkg.sv]
// Package for the button click pattern detector.
// Holds item, result, configuration and state types, and register indexes.
// No dependencies.
`default_nettype none

package bcpd_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TickW-1:0] ClickTicksRst = 16'd200;
  localparam logic [TickW-1:0] PressTicksRst = 16'd600;
  localparam logic [TickW-1:0] DebounceTicksRst = 16'd50;
  localparam logic ActiveLowRst = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLICK_TICKS    = 2'd0,
    REG_PRESS_TICKS    = 2'd1,
    REG_DEBOUNCE_TICKS = 2'd2,
    REG_ACTIVE_LOW     = 2'd3
  } reg_idx_t;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_FIRST  = 6'b000010,
    PH_WAIT2  = 6'b000100,
    PH_SECOND = 6'b001000,
    PH_THIRD  = 6'b010000,
    PH_LONG   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [TickW-1:0] click_ticks;
    logic [TickW-1:0] press_ticks;
    logic [TickW-1:0] debounce_ticks;
    logic             active_low;
  } cfg_t;

  typedef struct packed {
    logic             button_level;
    logic [TimeW-1:0] now_ms;
  } poll_t;

  typedef struct packed {
    logic click_event;
    logic double_click_event;
    logic triple_click_event;
    logic long_start_event;
    logic during_long_event;
    logic long_stop_event;
    logic long_held;
  } report_t;

  typedef struct packed {
    phase_t           phase;
    logic [TimeW-1:0] press_start_time;
    logic             long_flag;
  } state_t;

endpackage

`default_nettype wire

[sv/bcpd_if.sv]
// Valid/ready channel interfaces for poll items and report items.
// Depends on bcpd_pkg.
`default_nettype none

interface bcpd_poll_if;
  logic            valid;
  logic            ready;
  bcpd_pkg::poll_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bcpd_report_if;
  logic              valid;
  logic              ready;
  bcpd_pkg::report_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

[sv/button_click_pattern_detector.sv]
// Button click pattern detector: one report item per accepted poll item.
// Path: input register then result register; the report becomes valid when the item moves
// from the input register into the result register, which waits while a report is stalled.
// One item per cycle while reports are taken; the state update is one subtract-compare pass.
// Synchronous active-high reset: idle phase, press time 0, no long press, default registers.
// Depends on bcpd_pkg, bcpd_if, bcpd_cfg, bcpd_step.
`default_nettype none

module button_click_pattern_detector (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [bcpd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [bcpd_pkg::TickW-1:0]   cfg_data,
  bcpd_poll_if.sink                         poll,
  bcpd_report_if.source                     report
);

  bcpd_pkg::cfg_t    cfg;
  bcpd_pkg::state_t  state;
  bcpd_pkg::state_t  state_next;
  bcpd_pkg::poll_t   s1_item;
  bcpd_pkg::report_t res_next;
  bcpd_pkg::report_t res_item;
  logic              s1_valid;
  logic              res_valid;
  logic              adv;

  bcpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcpd_step u_step (
    .cfg        (cfg),
    .state      (state),
    .poll       (s1_item),
    .state_next (state_next),
    .report     (res_next)
  );

  assign adv          = s1_valid && (!res_valid || report.ready);
  assign poll.ready   = !s1_valid || adv;
  assign report.valid = res_valid;
  assign report.item  = res_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      state     <= '{phase: bcpd_pkg::PH_IDLE, press_start_time: '0, long_flag: 1'b0};
    end else begin
      if (poll.valid && poll.ready) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        res_valid <= 1'b1;
        state     <= state_next;
      end else if (report.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_item <= poll.item;
    end
    if (adv) begin
      res_item <= res_next;
    end
  end

  a_long_flag_phase: assert property (@(posedge clk) disable iff (rst)
    state.long_flag == (state.phase == bcpd_pkg::PH_LONG))
    else $error("long flag out of step with phase");

  a_adv_fills_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> res_valid)
    else $error("advanced item lost before result register");

  a_click_kinds_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({res_item.click_event, res_item.double_click_event,
                            res_item.triple_click_event, res_item.long_stop_event,
                            res_item.long_start_event}))
    else $error("more than one terminal event in one item");

  a_long_start_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.long_start_event |->
      res_item.during_long_event && res_item.long_held)
    else $error("long start without held flags");

endmodule

`default_nettype wire

[sv/bcpd_cfg.sv]
// Configuration registers with their reset values.
// Depends on bcpd_pkg.
`default_nettype none

module bcpd_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bcpd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [bcpd_pkg::TickW-1:0]     cfg_data,
  output bcpd_pkg::cfg_t                      cfg
);

  bcpd_pkg::reg_idx_t idx;
  assign idx = bcpd_pkg::reg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.click_ticks    <= bcpd_pkg::ClickTicksRst;
      cfg.press_ticks    <= bcpd_pkg::PressTicksRst;
      cfg.debounce_ticks <= bcpd_pkg::DebounceTicksRst;
      cfg.active_low     <= bcpd_pkg::ActiveLowRst;
    end else if (cfg_we) begin
      unique case (idx)
        bcpd_pkg::REG_CLICK_TICKS:    cfg.click_ticks    <= cfg_data;
        bcpd_pkg::REG_PRESS_TICKS:    cfg.press_ticks    <= cfg_data;
        bcpd_pkg::REG_DEBOUNCE_TICKS: cfg.debounce_ticks <= cfg_data;
        bcpd_pkg::REG_ACTIVE_LOW:     cfg.active_low     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/bcpd_step.sv]
// Next-state and report logic for one poll item.
// Depends on bcpd_pkg.
`default_nettype none

module bcpd_step (
  input  wire bcpd_pkg::cfg_t    cfg,
  input  wire bcpd_pkg::state_t  state,
  input  wire bcpd_pkg::poll_t   poll,
  output bcpd_pkg::state_t  state_next,
  output bcpd_pkg::report_t report
);

  logic                          pressed;
  logic [bcpd_pkg::TimeW-1:0]    elapsed;
  logic [bcpd_pkg::TimeW-1:0]    click_t;
  logic [bcpd_pkg::TimeW-1:0]    click2_t;
  logic [bcpd_pkg::TimeW-1:0]    press_t;
  logic [bcpd_pkg::TimeW-1:0]    deb_t;

  assign pressed  = poll.button_level ^ cfg.active_low;
  assign elapsed  = poll.now_ms - state.press_start_time;
  assign click_t  = {{(bcpd_pkg::TimeW-bcpd_pkg::TickW){1'b0}}, cfg.click_ticks};
  assign click2_t = {click_t[bcpd_pkg::TimeW-2:0], 1'b0};
  assign press_t  = {{(bcpd_pkg::TimeW-bcpd_pkg::TickW){1'b0}}, cfg.press_ticks};
  assign deb_t    = {{(bcpd_pkg::TimeW-bcpd_pkg::TickW){1'b0}}, cfg.debounce_ticks};

  always_comb begin
    state_next = state;
    report     = '0;
    unique case (state.phase)
      bcpd_pkg::PH_FIRST: begin
        if (!pressed && elapsed < deb_t) begin
          state_next.phase = bcpd_pkg::PH_IDLE;
        end else if (!pressed) begin
          state_next.phase = bcpd_pkg::PH_WAIT2;
        end else if (elapsed > press_t) begin
          state_next.long_flag    = 1'b1;
          report.long_start_event  = 1'b1;
          report.during_long_event = 1'b1;
          state_next.phase        = bcpd_pkg::PH_LONG;
        end
      end
      bcpd_pkg::PH_WAIT2: begin
        if (elapsed > click_t) begin
          report.click_event = 1'b1;
          state_next.phase   = bcpd_pkg::PH_IDLE;
        end else if (pressed) begin
          state_next.phase = bcpd_pkg::PH_SECOND;
        end
      end
      bcpd_pkg::PH_SECOND: begin
        if (elapsed > click2_t) begin
          if (!pressed) begin
            report.double_click_event = 1'b1;
            state_next.phase          = bcpd_pkg::PH_IDLE;
          end else begin
            state_next.phase = bcpd_pkg::PH_THIRD;
          end
        end
      end
      bcpd_pkg::PH_THIRD: begin
        if (!pressed) begin
          report.triple_click_event = 1'b1;
          state_next.phase          = bcpd_pkg::PH_IDLE;
        end
      end
      bcpd_pkg::PH_LONG: begin
        if (!pressed) begin
          state_next.long_flag   = 1'b0;
          report.long_stop_event = 1'b1;
          state_next.phase       = bcpd_pkg::PH_IDLE;
        end else begin
          state_next.long_flag     = 1'b1;
          report.during_long_event = 1'b1;
        end
      end
      default: begin
        // idle, and any stray code
        if (pressed) begin
          state_next.phase            = bcpd_pkg::PH_FIRST;
          state_next.press_start_time = poll.now_ms;
        end else begin
          state_next.phase = bcpd_pkg::PH_IDLE;
        end
      end
    endcase
    report.long_held = state_next.long_flag;
  end

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for button_click_pattern_detector: directed polls, then gesture-shaped
// random polls under several register settings; reports checked against table or predictor.
// Depends on bcpd_pkg, bcpd_if and the detector RTL.

module testbench;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned DirRows    = 24;

  typedef struct packed {
    logic                       level;
    logic [bcpd_pkg::TimeW-1:0] at_ms;
    logic                       typed;
    bcpd_pkg::report_t          want;
  } dir_row_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [bcpd_pkg::CfgIdxW-1:0] cfg_index;
  logic [bcpd_pkg::TickW-1:0]   cfg_data;

  bcpd_poll_if   poll_ch ();
  bcpd_report_if report_ch ();

  button_click_pattern_detector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .poll      (poll_ch),
    .report    (report_ch)
  );

  // predictor copy of registers and state
  bcpd_pkg::cfg_t             shadow_cfg;
  bcpd_pkg::phase_t           gest_phase;
  logic [bcpd_pkg::TimeW-1:0] press_t0;
  logic                       long_on;

  bcpd_pkg::report_t          pending_reports [$];
  dir_row_t                   dir_tab [DirRows];
  logic [bcpd_pkg::TimeW-1:0] clock_ms;
  int                         fail_count;
  int                         polls_sent;
  int                         reports_seen;
  int                         idle_cycles;
  bit                         hold_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bcpd_pkg::report_t detect_gesture(bcpd_pkg::poll_t p);
    bcpd_pkg::report_t          r;
    logic                       pressed;
    logic [bcpd_pkg::TimeW-1:0] elapsed;
    logic [bcpd_pkg::TimeW-1:0] dbl_win;
    r       = '0;
    pressed = p.button_level ^ shadow_cfg.active_low;
    elapsed = p.now_ms - press_t0;
    dbl_win = {15'd0, shadow_cfg.click_ticks, 1'b0};
    case (gest_phase)
      bcpd_pkg::PH_FIRST: begin
        if (!pressed && elapsed < {16'd0, shadow_cfg.debounce_ticks}) begin
          gest_phase = bcpd_pkg::PH_IDLE;
        end else if (!pressed) begin
          gest_phase = bcpd_pkg::PH_WAIT2;
        end else if (elapsed > {16'd0, shadow_cfg.press_ticks}) begin
          long_on             = 1'b1;
          r.long_start_event  = 1'b1;
          r.during_long_event = 1'b1;
          gest_phase          = bcpd_pkg::PH_LONG;
        end
      end
      bcpd_pkg::PH_WAIT2: begin
        if (elapsed > {16'd0, shadow_cfg.click_ticks}) begin
          r.click_event = 1'b1;
          gest_phase    = bcpd_pkg::PH_IDLE;
        end else if (pressed) begin
          gest_phase = bcpd_pkg::PH_SECOND;
        end
      end
      bcpd_pkg::PH_SECOND: begin
        if (elapsed > dbl_win) begin
          if (!pressed) begin
            r.double_click_event = 1'b1;
            gest_phase           = bcpd_pkg::PH_IDLE;
          end else begin
            gest_phase = bcpd_pkg::PH_THIRD;
          end
        end
      end
      bcpd_pkg::PH_THIRD: begin
        if (!pressed) begin
          r.triple_click_event = 1'b1;
          gest_phase           = bcpd_pkg::PH_IDLE;
        end
      end
      bcpd_pkg::PH_LONG: begin
        if (!pressed) begin
          long_on           = 1'b0;
          r.long_stop_event = 1'b1;
          gest_phase        = bcpd_pkg::PH_IDLE;
        end else begin
          r.during_long_event = 1'b1;
        end
      end
      default: begin
        if (pressed) begin
          gest_phase = bcpd_pkg::PH_FIRST;
          press_t0   = p.now_ms;
        end
      end
    endcase
    r.long_held = long_on;
    return r;
  endfunction

  // short gaps mostly, a few long, and stretches with none
  function automatic int pick_gap(int count);
    int r;
    r = $urandom_range(0, 99);
    if ((count / 48) % 4 == 1) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [bcpd_pkg::TimeW-1:0] pick_dur();
    logic [bcpd_pkg::TimeW-1:0] deb;
    logic [bcpd_pkg::TimeW-1:0] clk_t;
    logic [bcpd_pkg::TimeW-1:0] prs;
    logic [bcpd_pkg::TimeW-1:0] th;
    deb   = {16'd0, shadow_cfg.debounce_ticks};
    clk_t = {16'd0, shadow_cfg.click_ticks};
    prs   = {16'd0, shadow_cfg.press_ticks};
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, deb);
      1: begin
        case ($urandom_range(0, 3))
          0: th = deb;
          1: th = clk_t;
          2: th = clk_t << 1;
          default: th = prs;
        endcase
        return th + $urandom_range(0, 2) - 1;
      end
      2, 3, 4: return $urandom_range(deb, clk_t);
      5, 6: return $urandom_range(clk_t, (clk_t << 1) + 1);
      7, 8: return prs + $urandom_range(1, 400);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_poll(bcpd_pkg::poll_t p, bit use_want, bcpd_pkg::report_t want);
    int                gap;
    bcpd_pkg::report_t got;
    gap = pick_gap(polls_sent);
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    poll_ch.valid <= 1'b1;
    poll_ch.item  <= p;
    do @(posedge clk); while (!poll_ch.ready);
    got = detect_gesture(p);
    pending_reports.push_back(use_want ? want : got);
    polls_sent++;
    @(negedge clk);
  endtask

  task automatic send_at(bit pressed_now, logic [bcpd_pkg::TimeW-1:0] t);
    bcpd_pkg::poll_t p;
    p.button_level = pressed_now ^ shadow_cfg.active_low;
    p.now_ms       = t;
    send_poll(p, 1'b0, '0);
  endtask

  // polls spread over one press or release; an odd poll flips level as bounce
  task automatic emit_span(bit pressed_span, logic [bcpd_pkg::TimeW-1:0] dur);
    int          n;
    logic [63:0] off;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      off = ({32'd0, dur} * i) / n;
      send_at(pressed_span ^ ($urandom_range(0, 11) == 0),
              clock_ms + off[bcpd_pkg::TimeW-1:0]);
    end
    clock_ms += dur;
  endtask

  task automatic run_gesture();
    int                         presses;
    logic [bcpd_pkg::TimeW-1:0] tail;
    case ($urandom_range(0, 14))
      0: clock_ms = $urandom;
      1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        clock_ms += ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 3);
        send_at(1'($urandom_range(0, 1)), clock_ms);
      end
    end else begin
      presses = $urandom_range(1, 3);
      for (int k = 0; k < presses; k++) begin
        emit_span(1'b1, pick_dur());
        if (k < presses - 1) emit_span(1'b0, pick_dur());
      end
      tail = {15'd0, shadow_cfg.click_ticks, 1'b0} + shadow_cfg.press_ticks
             + $urandom_range(1, 100);
      emit_span(1'b0, tail);
      send_at(1'b0, clock_ms);
    end
  endtask

  // sender stops until every report is back, then the pipeline is left to empty
  task automatic wait_drained();
    poll_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [bcpd_pkg::TickW-1:0] ck, logic [bcpd_pkg::TickW-1:0] pr,
                           logic [bcpd_pkg::TickW-1:0] db,
                           logic [bcpd_pkg::TickW-1:0] al_word, int n);
    int target;
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      case (i)
        0: begin cfg_index <= bcpd_pkg::REG_CLICK_TICKS;    cfg_data <= ck; end
        1: begin cfg_index <= bcpd_pkg::REG_PRESS_TICKS;    cfg_data <= pr; end
        2: begin cfg_index <= bcpd_pkg::REG_DEBOUNCE_TICKS; cfg_data <= db; end
        default: begin cfg_index <= bcpd_pkg::REG_ACTIVE_LOW; cfg_data <= al_word; end
      endcase
      cfg_we <= 1'b1;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    shadow_cfg.click_ticks    = ck;
    shadow_cfg.press_ticks    = pr;
    shadow_cfg.debounce_ticks = db;
    shadow_cfg.active_low     = al_word[0];
    target = polls_sent + n;
    while (polls_sent < target) run_gesture();
  endtask

  task automatic check_flag(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_reports
    bcpd_pkg::report_t want;
    if (!rst && report_ch.valid && report_ch.ready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("report item with none expected");
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        check_flag("click_event", want.click_event, report_ch.item.click_event);
        check_flag("double_click_event", want.double_click_event,
                   report_ch.item.double_click_event);
        check_flag("triple_click_event", want.triple_click_event,
                   report_ch.item.triple_click_event);
        check_flag("long_start_event", want.long_start_event, report_ch.item.long_start_event);
        check_flag("during_long_event", want.during_long_event,
                   report_ch.item.during_long_event);
        check_flag("long_stop_event", want.long_stop_event, report_ch.item.long_stop_event);
        check_flag("long_held", want.long_held, report_ch.item.long_held);
      end
    end
  end

  always @(posedge clk) begin
    if ((poll_ch.valid && poll_ch.ready) || (report_ch.valid && report_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // receiver: random stalls, and once a long hold so the block backs up
  initial begin : receiver
    int gap;
    report_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!hold_done && reports_seen >= 300) begin
        hold_done = 1'b1;
        report_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end
      gap = pick_gap(reports_seen);
      if (gap > 0) begin
        report_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      report_ch.ready <= 1'b1;
    end
  end

  initial begin : stimulus
    bcpd_pkg::poll_t p;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = bcpd_pkg::REG_CLICK_TICKS;
    cfg_data      = '0;
    poll_ch.valid = 1'b0;
    poll_ch.item  = '0;
    fail_count    = 0;
    polls_sent    = 0;
    reports_seen  = 0;
    idle_cycles   = 0;
    hold_done     = 1'b0;
    shadow_cfg    = '{bcpd_pkg::ClickTicksRst, bcpd_pkg::PressTicksRst,
                      bcpd_pkg::DebounceTicksRst, bcpd_pkg::ActiveLowRst};
    gest_phase    = bcpd_pkg::PH_IDLE;
    press_t0      = '0;
    long_on       = 1'b0;
    clock_ms      = 32'd10000;

    // default registers: low level means pressed
    dir_tab = '{
      '{1'b1, 32'd0,          1'b1, 7'b0000000},
      '{1'b0, 32'd1000,       1'b1, 7'b0000000},
      '{1'b1, 32'd1010,       1'b1, 7'b0000000},  // bounce
      '{1'b0, 32'd2000,       1'b1, 7'b0000000},
      '{1'b1, 32'd2100,       1'b1, 7'b0000000},
      '{1'b1, 32'd2201,       1'b1, 7'b1000000},  // click
      '{1'b0, 32'd3000,       1'b0, 7'b0000000},
      '{1'b1, 32'd3100,       1'b0, 7'b0000000},
      '{1'b0, 32'd3150,       1'b0, 7'b0000000},
      '{1'b1, 32'd3401,       1'b1, 7'b0100000},  // double
      '{1'b0, 32'd4000,       1'b0, 7'b0000000},
      '{1'b1, 32'd4100,       1'b0, 7'b0000000},
      '{1'b0, 32'd4150,       1'b0, 7'b0000000},
      '{1'b0, 32'd4401,       1'b0, 7'b0000000},
      '{1'b1, 32'd4500,       1'b1, 7'b0010000},  // triple
      '{1'b0, 32'd5000,       1'b0, 7'b0000000},
      '{1'b0, 32'd5601,       1'b1, 7'b0001101},  // long start
      '{1'b0, 32'd6000,       1'b1, 7'b0000101},
      '{1'b1, 32'd6100,       1'b1, 7'b0000010},  // long stop
      '{1'b0, 32'hFFFF_FFF0,  1'b0, 7'b0000000},
      '{1'b1, 32'h0000_0010,  1'b1, 7'b0000000},  // bounce across the wrap
      '{1'b0, 32'hFFFF_FF00,  1'b0, 7'b0000000},
      '{1'b1, 32'h0000_0040,  1'b0, 7'b0000000},
      '{1'b1, 32'h0000_0041,  1'b1, 7'b1000000}   // click across the wrap
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DirRows; i++) begin
      p.button_level = dir_tab[i].level;
      p.now_ms       = dir_tab[i].at_ms;
      send_poll(p, dir_tab[i].typed, dir_tab[i].want);
    end

    run_phase(16'd200, 16'd600, 16'd50, 16'h0001, 80);
    run_phase(16'd0, 16'd0, 16'd0, 16'h0000, 100);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 100);
    run_phase(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFE, 90);
    run_phase(16'd0, 16'hFFFF, 16'd0, 16'h8001, 90);
    run_phase(16'd120, 16'd400, 16'd30, 16'h0000, 100);
    repeat (2) run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 80);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/bcpd_pkg.sv
sv/bcpd_if.sv
sv/bcpd_cfg.sv
sv/bcpd_step.sv
sv/button_click_pattern_detector.sv
test/testbench.sv
